FILE: rtl/irc_format_code_parser_assert.svh
// ----------------------------------------------------------------------------
// IRC format code parser assertion macros
// Concurrent check shorthands shared by the parser's RTL.
// ----------------------------------------------------------------------------
`ifndef IRC_FORMAT_CODE_PARSER_ASSERT_SVH
`define IRC_FORMAT_CODE_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IRC_CHECK_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IRC_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ircfcp_pkg.sv
// ----------------------------------------------------------------------------
// IRC format code parser package
// Shared types, event codes, byte codes and the parser's reset state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ircfcp_pkg;

   localparam int NumSlots = 16;

   localparam logic [3:0] EvLiteral   = 4'd0;
   localparam logic [3:0] EvBoldOn    = 4'd1;
   localparam logic [3:0] EvBoldOff   = 4'd2;
   localparam logic [3:0] EvItalicOn  = 4'd3;
   localparam logic [3:0] EvItalicOff = 4'd4;
   localparam logic [3:0] EvUnderOn   = 4'd5;
   localparam logic [3:0] EvUnderOff  = 4'd6;
   localparam logic [3:0] EvFgSet     = 4'd7;
   localparam logic [3:0] EvFgEnd     = 4'd8;
   localparam logic [3:0] EvBgSet     = 4'd9;
   localparam logic [3:0] EvBgEnd     = 4'd10;
   localparam logic [3:0] EvEnd       = 4'd11;

   localparam logic [4:0] DefFg     = 5'd16;
   localparam logic [4:0] DefBg     = 5'd17;
   localparam logic [4:0] NoColour  = 5'd31;
   localparam logic [4:0] MaxColour = 5'd15;

   localparam logic [7:0] ChBold     = 8'h02;
   localparam logic [7:0] ChColour   = 8'h03;
   localparam logic [7:0] ChBell     = 8'h07;
   localparam logic [7:0] ChLineFeed = 8'h0A;
   localparam logic [7:0] ChPlain    = 8'h0F;
   localparam logic [7:0] ChSwap     = 8'h16;
   localparam logic [7:0] ChItalic   = 8'h1D;
   localparam logic [7:0] ChUnder    = 8'h1F;
   localparam logic [7:0] ChSpace    = 8'h20;
   localparam logic [7:0] ChComma    = 8'h2C;
   localparam logic [7:0] ChZero     = 8'h30;
   localparam logic [7:0] ChNine     = 8'h39;

   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_START    = 6'b000010,
      PH_FG_DIGIT = 6'b000100,
      PH_FG_KNOWN = 6'b001000,
      PH_COMMA    = 6'b010000,
      PH_BG_DIGIT = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] lit;
      logic [4:0] colour;
   } evt_type;

   typedef struct packed {
      logic      bold;
      logic      italic;
      logic      underline;
      logic [4:0] fore;
      logic [4:0] back;
      phase_type  phase;
      logic [4:0] pend_fore;
      logic [4:0] pend_back;
      logic [3:0] held;
   } pst_type;

   typedef struct packed {
      logic [NumSlots-1:0]          valid;
      evt_type [NumSlots-1:0]       evts;
   } batch_type;

   localparam pst_type StateReset = '{
      bold:      1'b0,
      italic:    1'b0,
      underline: 1'b0,
      fore:      DefFg,
      back:      DefBg,
      phase:     PH_IDLE,
      pend_fore: NoColour,
      pend_back: NoColour,
      held:      4'd0
   };

endpackage

FILE: rtl/ircfcp_step.sv
// ----------------------------------------------------------------------------
// IRC format code parser step logic
// Decodes one text byte against the style state into a batch of event slots
// and the next style state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ircfcp_step (
   input  ircfcp_pkg::pst_type   st,
   input  logic [7:0]            text_byte,
   input  logic                  final_byte,
   output ircfcp_pkg::pst_type   st_next,
   output ircfcp_pkg::batch_type batch
);
   import ircfcp_pkg::*;

   localparam int SlotResolve = 0;
   localparam int SlotHeld    = 2;
   localparam int SlotIdle    = 3;
   localparam int SlotFinal   = 8;
   localparam int SlotFlush   = 10;
   localparam int SlotEnd     = 15;

   typedef struct packed {
      pst_type        s;
      evt_type [1:0]  e;
      logic [1:0]     v;
   } res_out_type;

   typedef struct packed {
      pst_type        s;
      evt_type [4:0]  e;
      logic [4:0]     v;
   } idle_out_type;

   function automatic evt_type mk_evt(input logic [3:0] kind, input logic [7:0] lit,
                                      input logic [4:0] colour);
      evt_type e;
      e.kind   = kind;
      e.lit    = lit;
      e.colour = colour;
      return e;
   endfunction

   function automatic res_out_type resolve_colour(input pst_type si);
      res_out_type r;
      r.s = si;
      r.e = '0;
      r.v = '0;
      if (si.pend_fore == NoColour) begin
         if (si.fore != DefFg) begin
            r.v[0] = 1'b1;
            r.e[0] = mk_evt(EvFgEnd, 8'd0, 5'd0);
         end
         if (si.back != DefBg) begin
            r.v[1] = 1'b1;
            r.e[1] = mk_evt(EvBgEnd, 8'd0, 5'd0);
         end
         r.s.fore = DefFg;
         r.s.back = DefBg;
      end else begin
         r.s.fore = si.pend_fore;
         r.v[0]   = 1'b1;
         r.e[0]   = mk_evt(EvFgSet, 8'd0, si.pend_fore);
         if (si.pend_back != NoColour) begin
            r.s.back = si.pend_back;
            r.v[1]   = 1'b1;
            r.e[1]   = mk_evt(EvBgSet, 8'd0, si.pend_back);
         end
      end
      r.s.phase     = PH_IDLE;
      r.s.pend_fore = NoColour;
      r.s.pend_back = NoColour;
      return r;
   endfunction

   function automatic idle_out_type handle_idle(input pst_type si, input logic [7:0] c);
      idle_out_type h;
      h.s = si;
      h.e = '0;
      h.v = '0;
      if (c >= ChSpace || c == ChBell || c == ChLineFeed) begin
         h.v[0] = 1'b1;
         h.e[0] = mk_evt(EvLiteral, c, 5'd0);
      end else begin
         case (c)
            ChBold: begin
               h.s.bold = ~si.bold;
               h.v[0]   = 1'b1;
               h.e[0]   = mk_evt(h.s.bold ? EvBoldOn : EvBoldOff, 8'd0, 5'd0);
            end
            ChItalic: begin
               h.s.italic = ~si.italic;
               h.v[0]     = 1'b1;
               h.e[0]     = mk_evt(h.s.italic ? EvItalicOn : EvItalicOff, 8'd0, 5'd0);
            end
            ChUnder: begin
               h.s.underline = ~si.underline;
               h.v[0]        = 1'b1;
               h.e[0]        = mk_evt(h.s.underline ? EvUnderOn : EvUnderOff, 8'd0, 5'd0);
            end
            ChPlain: begin
               h.v[0] = si.bold;
               h.e[0] = mk_evt(EvBoldOff, 8'd0, 5'd0);
               h.v[1] = si.italic;
               h.e[1] = mk_evt(EvItalicOff, 8'd0, 5'd0);
               h.v[2] = si.underline;
               h.e[2] = mk_evt(EvUnderOff, 8'd0, 5'd0);
               h.v[3] = (si.fore != DefFg);
               h.e[3] = mk_evt(EvFgEnd, 8'd0, 5'd0);
               h.v[4] = (si.back != DefBg);
               h.e[4] = mk_evt(EvBgEnd, 8'd0, 5'd0);
               h.s.bold      = 1'b0;
               h.s.italic    = 1'b0;
               h.s.underline = 1'b0;
               h.s.fore      = DefFg;
               h.s.back      = DefBg;
            end
            ChSwap: begin
               h.s.fore = si.back;
               h.s.back = si.fore;
               h.v[1:0] = 2'b11;
               h.e[0] = (si.back == DefFg) ? mk_evt(EvFgEnd, 8'd0, 5'd0)
                                           : mk_evt(EvFgSet, 8'd0, si.back);
               h.e[1] = (si.fore == DefBg) ? mk_evt(EvBgEnd, 8'd0, 5'd0)
                                           : mk_evt(EvBgSet, 8'd0, si.fore);
            end
            ChColour: begin
               h.s.phase     = PH_START;
               h.s.pend_fore = NoColour;
               h.s.pend_back = NoColour;
            end
            default: begin
            end
         endcase
      end
      return h;
   endfunction

   pst_type      s;
   res_out_type  r1;
   res_out_type  r2;
   idle_out_type h;
   logic         is_digit;
   logic         two_ok;
   logic [6:0]   two_val;
   logic         do_resolve;
   logic         do_held;
   logic         do_idle;
   logic [7:0]   held_lit;

   always_comb begin
      s          = st;
      batch      = '0;
      do_resolve = 1'b0;
      do_held    = 1'b0;
      do_idle    = 1'b0;
      r1         = '0;
      r2         = '0;
      h          = '0;
      is_digit   = (text_byte >= ChZero) && (text_byte <= ChNine);
      two_val    = {3'b000, st.held} * 7'd10 + {3'b000, text_byte[3:0]};
      two_ok     = (two_val <= 7'(MaxColour));
      held_lit   = ChZero | {4'h0, st.held};

      unique case (st.phase)
         PH_START: begin
            if (is_digit) begin
               s.held  = text_byte[3:0];
               s.phase = PH_FG_DIGIT;
            end else begin
               do_resolve = 1'b1;
               do_idle    = 1'b1;
            end
         end
         PH_FG_DIGIT: begin
            if (is_digit) begin
               if (two_ok) begin
                  s.pend_fore = two_val[4:0];
                  s.phase     = PH_FG_KNOWN;
               end else begin
                  do_resolve = 1'b1;
                  do_held    = 1'b1;
                  do_idle    = 1'b1;
               end
            end else begin
               s.pend_fore = {1'b0, st.held};
               if (text_byte == ChComma) begin
                  s.phase = PH_COMMA;
               end else begin
                  do_resolve = 1'b1;
                  do_idle    = 1'b1;
               end
            end
         end
         PH_FG_KNOWN: begin
            if (text_byte == ChComma) begin
               s.phase = PH_COMMA;
            end else begin
               do_resolve = 1'b1;
               do_idle    = 1'b1;
            end
         end
         PH_COMMA: begin
            if (is_digit) begin
               s.held  = text_byte[3:0];
               s.phase = PH_BG_DIGIT;
            end else begin
               do_resolve = 1'b1;
               do_idle    = 1'b1;
            end
         end
         PH_BG_DIGIT: begin
            do_resolve = 1'b1;
            if (is_digit) begin
               if (two_ok) begin
                  s.pend_back = two_val[4:0];
               end else begin
                  do_held = 1'b1;
                  do_idle = 1'b1;
               end
            end else begin
               s.pend_back = {1'b0, st.held};
               do_idle     = 1'b1;
            end
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase

      if (do_resolve) begin
         r1 = resolve_colour(s);
         s  = r1.s;
         batch.valid[SlotResolve +: 2] = r1.v;
         batch.evts[SlotResolve +: 2]  = r1.e;
      end
      if (do_held) begin
         batch.valid[SlotHeld] = 1'b1;
         batch.evts[SlotHeld]  = mk_evt(EvLiteral, held_lit, 5'd0);
      end
      if (do_idle) begin
         h = handle_idle(s, text_byte);
         s = h.s;
         batch.valid[SlotIdle +: 5] = h.v;
         batch.evts[SlotIdle +: 5]  = h.e;
      end

      if (final_byte) begin
         if (s.phase == PH_FG_DIGIT) begin
            s.pend_fore = {1'b0, s.held};
         end
         if (s.phase == PH_BG_DIGIT) begin
            s.pend_back = {1'b0, s.held};
         end
         if (s.phase != PH_IDLE) begin
            r2 = resolve_colour(s);
            s  = r2.s;
            batch.valid[SlotFinal +: 2] = r2.v;
            batch.evts[SlotFinal +: 2]  = r2.e;
         end
         batch.valid[SlotFlush]     = s.bold;
         batch.evts[SlotFlush]      = mk_evt(EvBoldOff, 8'd0, 5'd0);
         batch.valid[SlotFlush + 1] = s.italic;
         batch.evts[SlotFlush + 1]  = mk_evt(EvItalicOff, 8'd0, 5'd0);
         batch.valid[SlotFlush + 2] = s.underline;
         batch.evts[SlotFlush + 2]  = mk_evt(EvUnderOff, 8'd0, 5'd0);
         batch.valid[SlotFlush + 3] = (s.fore != DefFg);
         batch.evts[SlotFlush + 3]  = mk_evt(EvFgEnd, 8'd0, 5'd0);
         batch.valid[SlotFlush + 4] = (s.back != DefBg);
         batch.evts[SlotFlush + 4]  = mk_evt(EvBgEnd, 8'd0, 5'd0);
         batch.valid[SlotEnd]       = 1'b1;
         batch.evts[SlotEnd]        = mk_evt(EvEnd, 8'd0, 5'd0);
         s = StateReset;
      end

      st_next = s;
   end

endmodule

FILE: rtl/ircfcp_evq.sv
// ----------------------------------------------------------------------------
// IRC format code parser event queue
// Holds the event batch of one request and hands its events out one per
// cycle while rsp_stall is low, lowest slot first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ircfcp_evq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ircfcp_pkg::batch_type load_batch,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output ircfcp_pkg::evt_type   rsp_evt,
   output logic                  rsp_run_end,
   output logic                  free
);
   import ircfcp_pkg::*;

   logic [NumSlots-1:0]    mask_ff;
   logic [NumSlots-1:0]    mask_in;
   evt_type [NumSlots-1:0] evts_ff;
   logic [NumSlots-1:0]    low;
   logic                   pop;

   assign low         = mask_ff & (~mask_ff + {{(NumSlots-1){1'b0}}, 1'b1});
   assign rsp_valid   = |mask_ff;
   assign rsp_run_end = ((mask_ff & ~low) == '0);
   assign pop         = rsp_valid && !rsp_stall;
   assign free        = !rsp_valid || (pop && rsp_run_end);

   always_comb begin
      rsp_evt = '0;
      for (int i = 0; i < NumSlots; i++) begin
         if (low[i]) begin
            rsp_evt = rsp_evt | evts_ff[i];
         end
      end
   end

   always_comb begin
      if (load) begin
         mask_in = load_batch.valid;
      end else if (pop) begin
         mask_in = mask_ff & ~low;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         evts_ff <= load_batch.evts;
      end
   end

endmodule

FILE: rtl/irc_format_code_parser.sv
// ----------------------------------------------------------------------------
// IRC format code parser
// Turns chat text bytes carrying IRC formatting codes into a stream of
// literal and style events.
//
//   Channel | Direction | Ports                                  | Meaning
//   req     | in        | valid, stall, text_byte, final_byte    | one text byte
//   rsp     | out       | valid, stall, event_kind, literal_value,| one event
//           |           | colour_code, run_end                   |
//
// A request is registered, decoded combinationally and its events are loaded
// into the event queue. The queue shows one event per cycle while rsp_stall
// is low; requests with zero or one event then sustain one request per
// cycle. A request is decoded in the same cycle that the queue hands out
// its previous last event. Reset is synchronous and returns all styles to
// their defaults. A stall on the result side backs up into req_stall once
// the input register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irc_format_code_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_event_kind,
   output logic [7:0] rsp_literal_value,
   output logic [4:0] rsp_colour_code,
   output logic       rsp_run_end
);
   import ircfcp_pkg::*;

   `include "irc_format_code_parser_assert.svh"

   logic       req_valid_ff;
   logic       req_valid_in;
   logic [7:0] req_byte_ff;
   logic       req_final_ff;
   pst_type    st_ff;
   pst_type    st_in;
   pst_type    st_next;
   batch_type  batch;
   evt_type    rsp_evt;
   logic       free;
   logic       consume;
   logic       accept;
   logic       pop;

   assign consume   = req_valid_ff && free;
   assign req_stall = req_valid_ff && !free;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      if (accept) begin
         req_valid_in = 1'b1;
      end else if (consume) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   assign st_in = consume ? st_next : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         st_ff        <= StateReset;
      end else begin
         req_valid_ff <= req_valid_in;
         st_ff        <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_byte_ff  <= req_text_byte;
         req_final_ff <= req_final_byte;
      end
   end

   ircfcp_step u_step (
      .st         (st_ff),
      .text_byte  (req_byte_ff),
      .final_byte (req_final_ff),
      .st_next    (st_next),
      .batch      (batch)
   );

   ircfcp_evq u_evq (
      .clock       (clock),
      .reset       (reset),
      .load        (consume),
      .load_batch  (batch),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_evt     (rsp_evt),
      .rsp_run_end (rsp_run_end),
      .free        (free)
   );

   assign rsp_event_kind    = rsp_evt.kind;
   assign rsp_literal_value = rsp_evt.lit;
   assign rsp_colour_code   = rsp_evt.colour;

   `IRC_CHECK_SAME(a_stall_needs_held_request, clock, reset,
      req_stall, req_valid_ff, "request stalled with an empty input register")
   `IRC_CHECK_NEXT(a_final_restores_reset, clock, reset,
      consume && req_final_ff, st_ff == StateReset, "style state not reset after final byte")
   `IRC_CHECK_NEXT(a_last_event_drains, clock, reset,
      pop && rsp_run_end && !consume, !rsp_valid, "event queue not empty after last event")

endmodule
